@@ sv/sgcp_pkg.sv @@
// Shared types and constants for the scatter-gather copy planner.
package sgcp_pkg;

    localparam int LEN_W  = 13;
    localparam int CNT_W  = 31;
    localparam int ADDR_W = 48;

    typedef enum logic [1:0] {
        OP_CLEAR      = 2'd0,
        OP_APPEND_SRC = 2'd1,
        OP_APPEND_DST = 2'd2,
        OP_COPY       = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [LEN_W-1:0] piece;
        logic             src_adv;
        logic             dst_adv;
        logic [LEN_W-1:0] next_soff;
        logic [LEN_W-1:0] next_doff;
        logic [CNT_W-1:0] next_rem;
    } t_step_res;

endpackage

@@ sv/scatter_gather_copy_planner_unit.sv @@
// Scatter-gather copy planner: source and destination lists and the copy sequencer.
// Clear and append commands return one status beat each. A copy runs one skip step for
// each source entry skipped by the offset and one merge step per segment or passed-over
// zero-length entry, with accept, setup and summary around them; the registered read
// of the entry memories puts a wait state after each skip and merge step. Skip and
// merge steps together number at most 2*MAX_ENTRIES-1. The block accepts no new beat
// until the current command has produced its final beat into the output register.
module scatter_gather_copy_planner_unit
    import sgcp_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int PAGE_BYTES  = 4096,
    parameter int ADDR_BITS   = 48
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // entry_address, entry_bytes, source_offset, request_bytes, zero pad.
    input  logic [127:0]   s_axis_tdata,
    // opcode.
    input  logic [1:0]     s_axis_tuser,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // segment_source, segment_dest, segment_bytes, total_copied, list_full, zero pad.
    output logic [143:0]   m_axis_tdata,
    output logic           m_axis_tlast
);

    localparam int AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam logic [NW-1:0] MAX_N = NW'(MAX_ENTRIES);
    localparam logic [16:0] PAGE_LIM = 17'(PAGE_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STATUS,
        ST_SKIP_WAIT,
        ST_SKIP,
        ST_MERGE,
        ST_MERGE_WAIT,
        ST_SUMMARY
    } t_state;

    t_state           r_state;
    logic             r_m_valid;
    logic [143:0]     r_m_data;
    logic             r_m_last;
    logic [NW-1:0]    r_src_total;
    logic [NW-1:0]    r_dst_total;
    logic             r_full;
    logic [NW-1:0]    r_si;
    logic [NW-1:0]    r_di;
    logic [CNT_W-1:0] r_soff;
    logic [LEN_W-1:0] r_doff;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_req;

    logic [AW-1:0]    src_base_mem [MAX_ENTRIES];
    logic [LEN_W-1:0] src_len_mem  [MAX_ENTRIES];
    logic [AW-1:0]    dst_base_mem [MAX_ENTRIES];
    logic [LEN_W-1:0] dst_len_mem  [MAX_ENTRIES];
    logic [AW-1:0]    r_src_base_q;
    logic [LEN_W-1:0] r_src_len_q;
    logic [AW-1:0]    r_dst_base_q;
    logic [LEN_W-1:0] r_dst_len_q;

    t_opcode          in_op;
    logic [ADDR_W-1:0] in_addr;
    logic [LEN_W-1:0] in_bytes;
    logic [CNT_W-1:0] in_offset;
    logic [CNT_W-1:0] in_req;
    logic [LEN_W-1:0] in_bytes_clamped;
    logic             in_accept;
    logic             can_put;
    logic             out_load;
    logic             src_wr;
    logic             dst_wr;
    logic             merge_live;
    logic [AW-1:0]    seg_src;
    logic [AW-1:0]    seg_dst;
    t_step_res        step;

    assign in_op     = t_opcode'(s_axis_tuser);
    assign in_addr   = s_axis_tdata[47:0];
    assign in_bytes  = s_axis_tdata[60:48];
    assign in_offset = s_axis_tdata[91:61];
    assign in_req    = s_axis_tdata[122:92];
    assign in_bytes_clamped = ({4'b0, in_bytes} > PAGE_LIM) ? LEN_W'(PAGE_LIM) : in_bytes;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign can_put       = !r_m_valid || m_axis_tready;
    assign src_wr = in_accept && (in_op == OP_APPEND_SRC) && (r_src_total < MAX_N);
    assign dst_wr = in_accept && (in_op == OP_APPEND_DST) && (r_dst_total < MAX_N);
    assign merge_live = (r_rem != '0) && (r_si < r_src_total) && (r_di < r_dst_total);
    assign out_load = can_put && ((r_state == ST_STATUS) || (r_state == ST_SUMMARY) ||
                                  ((r_state == ST_MERGE) && merge_live &&
                                   (step.piece != '0)));
    assign seg_src = r_src_base_q + AW'(r_soff[LEN_W-1:0]);
    assign seg_dst = r_dst_base_q + AW'(r_doff);

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    sgcp_merge_step u_step (
        .i_slen (r_src_len_q),
        .i_dlen (r_dst_len_q),
        .i_soff (r_soff[LEN_W-1:0]),
        .i_doff (r_doff),
        .i_rem  (r_rem),
        .o_res  (step)
    );

    function automatic logic [143:0] pack_out(
        input logic [ADDR_W-1:0] src,
        input logic [ADDR_W-1:0] dst,
        input logic [LEN_W-1:0]  len,
        input logic [CNT_W-1:0]  total,
        input logic              full
    );
        return {3'b0, full, total, len, dst, src};
    endfunction

    always_ff @(posedge i_clk) begin
        if (src_wr) begin
            src_base_mem[r_src_total[IW-1:0]] <= in_addr[AW-1:0];
            src_len_mem[r_src_total[IW-1:0]]  <= in_bytes_clamped;
        end
        if (dst_wr) begin
            dst_base_mem[r_dst_total[IW-1:0]] <= in_addr[AW-1:0];
            dst_len_mem[r_dst_total[IW-1:0]]  <= in_bytes_clamped;
        end
        r_src_base_q <= src_base_mem[r_si[IW-1:0]];
        r_src_len_q  <= src_len_mem[r_si[IW-1:0]];
        r_dst_base_q <= dst_base_mem[r_di[IW-1:0]];
        r_dst_len_q  <= dst_len_mem[r_di[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_m_valid   <= 1'b0;
            r_src_total <= '0;
            r_dst_total <= '0;
            r_full      <= 1'b0;
        end else begin
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= (in_op == OP_COPY) ? ST_SKIP_WAIT : ST_STATUS;
                        case (in_op)
                            OP_CLEAR: begin
                                r_src_total <= '0;
                                r_dst_total <= '0;
                                r_full      <= 1'b0;
                            end
                            OP_APPEND_SRC: begin
                                if (src_wr) begin
                                    r_src_total <= r_src_total + NW'(1);
                                end else begin
                                    r_full <= 1'b1;
                                end
                            end
                            OP_APPEND_DST: begin
                                if (dst_wr) begin
                                    r_dst_total <= r_dst_total + NW'(1);
                                end else begin
                                    r_full <= 1'b1;
                                end
                            end
                            default: begin
                                r_si    <= '0;
                                r_di    <= '0;
                                r_soff  <= in_offset;
                                r_doff  <= '0;
                                r_rem   <= in_req;
                                r_req   <= in_req;
                            end
                        endcase
                    end
                end
                ST_STATUS: begin
                    if (can_put) begin
                        r_m_data  <= pack_out('0, '0, '0, '0, r_full);
                        r_m_last  <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                ST_SKIP_WAIT: begin
                    r_state <= ST_SKIP;
                end
                ST_SKIP: begin
                    if ((r_si < r_src_total) && (r_soff >= CNT_W'(r_src_len_q))) begin
                        r_soff  <= r_soff - CNT_W'(r_src_len_q);
                        r_si    <= r_si + NW'(1);
                        r_state <= ST_SKIP_WAIT;
                    end else begin
                        r_state <= ST_MERGE;
                    end
                end
                ST_MERGE: begin
                    if (merge_live) begin
                        if ((step.piece == '0) || can_put) begin
                            if (step.piece != '0) begin
                                r_m_data  <= pack_out(ADDR_W'(seg_src), ADDR_W'(seg_dst),
                                                      step.piece, '0, r_full);
                                r_m_last  <= 1'b0;
                            end
                            r_si    <= r_si + NW'(step.src_adv);
                            r_di    <= r_di + NW'(step.dst_adv);
                            r_soff  <= CNT_W'(step.next_soff);
                            r_doff  <= step.next_doff;
                            r_rem   <= step.next_rem;
                            r_state <= ST_MERGE_WAIT;
                        end
                    end else begin
                        r_state <= ST_SUMMARY;
                    end
                end
                ST_MERGE_WAIT: begin
                    r_state <= ST_MERGE;
                end
                ST_SUMMARY: begin
                    if (can_put) begin
                        r_m_data  <= pack_out('0, '0, '0, r_req - r_rem, r_full);
                        r_m_last  <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_src_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != ST_IDLE) && (r_state != ST_STATUS)) |-> (r_si <= r_src_total))
        else $error("source index ran past the source list");

    a_list_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_src_total <= MAX_N) && (r_dst_total <= MAX_N))
        else $error("list count exceeds capacity");

    a_summary_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[108:96] == '0))
        else $error("summary beat carries a segment length");

    a_copy_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (in_op == OP_COPY)) |=> !s_axis_tready)
        else $error("copy accepted without leaving idle");
`endif

endmodule

@@ sv/sgcp_merge_step.sv @@
// One merge step: piece length and the updated list positions.
module sgcp_merge_step
    import sgcp_pkg::*;
(
    input  logic [LEN_W-1:0] i_slen,
    input  logic [LEN_W-1:0] i_dlen,
    input  logic [LEN_W-1:0] i_soff,
    input  logic [LEN_W-1:0] i_doff,
    input  logic [CNT_W-1:0] i_rem,
    output t_step_res        o_res
);

    logic [LEN_W-1:0] s_room;
    logic [LEN_W-1:0] d_room;
    logic [LEN_W-1:0] piece_sd;
    logic [LEN_W-1:0] piece;
    logic [LEN_W:0]   s_end;
    logic [LEN_W:0]   d_end;

    always_comb begin
        s_room   = i_slen - i_soff;
        d_room   = i_dlen - i_doff;
        piece_sd = (d_room < s_room) ? d_room : s_room;
        piece    = (i_rem < CNT_W'(piece_sd)) ? LEN_W'(i_rem) : piece_sd;
        s_end    = {1'b0, i_soff} + {1'b0, piece};
        d_end    = {1'b0, i_doff} + {1'b0, piece};

        o_res.piece     = piece;
        o_res.src_adv   = (s_end >= {1'b0, i_slen});
        o_res.dst_adv   = (d_end >= {1'b0, i_dlen});
        o_res.next_soff = o_res.src_adv ? '0 : s_end[LEN_W-1:0];
        o_res.next_doff = o_res.dst_adv ? '0 : d_end[LEN_W-1:0];
        o_res.next_rem  = i_rem - CNT_W'(piece);
    end

endmodule

@@ bench/scatter_gather_copy_planner_unit_tb.sv @@
// Self-checking testbench for the scatter-gather copy planner: list building, copies and idling.
`timescale 1ns / 1ps

module scatter_gather_copy_planner_unit_tb
    import sgcp_pkg::*;
();

    localparam int MAX_ENTRIES = 16;
    localparam int PAGE_BYTES  = 4096;
    localparam int MAX_SEGS    = 2 * MAX_ENTRIES - 1;
    localparam logic [30:0] CNT_MAX = 31'h7FFF_FFFF;

    typedef struct {
        logic [47:0] seg_src;
        logic [47:0] seg_dst;
        logic [12:0] seg_len;
        logic [30:0] total;
        logic        full;
        logic        last;
    } t_plan_beat;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tlast;

    logic [47:0] src_base [MAX_ENTRIES];
    logic [12:0] src_len  [MAX_ENTRIES];
    logic [47:0] dst_base [MAX_ENTRIES];
    logic [12:0] dst_len  [MAX_ENTRIES];
    int          src_count;
    int          dst_count;
    logic        overflow_seen;

    t_plan_beat planned_beats[$];
    int         errors;
    int         commands_sent;
    int         copies_sent;
    int         segments_seen;
    int         summaries_seen;
    int         full_beats_seen;
    bit         gapless;

    scatter_gather_copy_planner_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic void push_beat(logic [47:0] s, logic [47:0] d, logic [12:0] n,
                                      logic [30:0] tot, logic lst);
        t_plan_beat b;
        b.seg_src = s;
        b.seg_dst = d;
        b.seg_len = n;
        b.total   = tot;
        b.full    = overflow_seen;
        b.last    = lst;
        planned_beats.push_back(b);
    endfunction

    function automatic void plan_copy(logic [30:0] offset, logic [30:0] req);
        logic [31:0] off;
        logic [31:0] doff;
        logic [31:0] rem;
        logic [31:0] slen;
        logic [31:0] dlen;
        logic [31:0] piece;
        int          si;
        int          di;
        int          k;
        off  = {1'b0, offset};
        rem  = {1'b0, req};
        doff = 0;
        si   = 0;
        di   = 0;
        k    = 0;
        while (si < src_count && off >= {19'd0, src_len[si]}) begin
            off -= {19'd0, src_len[si]};
            si++;
        end
        while (rem > 0 && si < src_count && di < dst_count) begin
            slen  = {19'd0, src_len[si]};
            dlen  = {19'd0, dst_len[di]};
            piece = slen - off;
            if (dlen - doff < piece) piece = dlen - doff;
            if (rem < piece) piece = rem;
            if (piece > 0 && k < MAX_SEGS) begin
                push_beat(src_base[si] + off[47:0], dst_base[di] + doff[47:0],
                          piece[12:0], '0, 1'b0);
                k++;
            end
            if (off + piece >= slen) begin
                si++;
                off = 0;
            end else begin
                off += piece;
            end
            if (doff + piece >= dlen) begin
                di++;
                doff = 0;
            end else begin
                doff += piece;
            end
            rem -= piece;
        end
        push_beat('0, '0, '0, req - rem[30:0], 1'b1);
    endfunction

    function automatic void plan_command(t_opcode op, logic [47:0] addr, logic [12:0] nbytes,
                                         logic [30:0] offset, logic [30:0] req);
        logic [12:0] len;
        len = (nbytes > PAGE_BYTES) ? 13'(PAGE_BYTES) : nbytes;
        case (op)
            OP_CLEAR: begin
                src_count     = 0;
                dst_count     = 0;
                overflow_seen = 1'b0;
            end
            OP_APPEND_SRC: begin
                if (src_count >= MAX_ENTRIES) begin
                    overflow_seen = 1'b1;
                end else begin
                    src_base[src_count] = addr;
                    src_len[src_count]  = len;
                    src_count++;
                end
            end
            OP_APPEND_DST: begin
                if (dst_count >= MAX_ENTRIES) begin
                    overflow_seen = 1'b1;
                end else begin
                    dst_base[dst_count] = addr;
                    dst_len[dst_count]  = len;
                    dst_count++;
                end
            end
            default: begin
                plan_copy(offset, req);
                return;
            end
        endcase
        push_beat('0, '0, '0, '0, 1'b0);
    endfunction

    task automatic send_item(t_opcode op, logic [47:0] addr, logic [12:0] nbytes,
                             logic [30:0] offset, logic [30:0] req);
        @(negedge i_clk);
        while (!gapless && $urandom_range(99) < 15) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {5'd0, req, offset, nbytes, addr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        plan_command(op, addr, nbytes, offset, req);
        commands_sent++;
        if (op == OP_COPY) copies_sent++;
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= gapless || ($urandom_range(99) >= 15);
    end

    always @(posedge i_clk) begin
        t_plan_beat b;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (planned_beats.size() == 0) begin
                $error("Result beat arrived with nothing expected");
                errors++;
            end else begin
                b = planned_beats.pop_front();
                check_field("segment_source", b.seg_src, m_axis_tdata[47:0]);
                check_field("segment_dest", b.seg_dst, m_axis_tdata[95:48]);
                check_field("segment_bytes", b.seg_len, m_axis_tdata[108:96]);
                check_field("total_copied", b.total, m_axis_tdata[139:109]);
                check_field("list_full", b.full, m_axis_tdata[140]);
                check_field("last", b.last, m_axis_tlast);
                if (b.last) summaries_seen++;
                else if (b.seg_len != 0) segments_seen++;
                if (b.full) full_beats_seen++;
            end
        end
    end

    function automatic logic [47:0] rand_addr();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [30:0] rand_cnt();
        return 31'($urandom);
    endfunction

    function automatic logic [12:0] rand_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return 13'($urandom_range(PAGE_BYTES, 1));
        if (pick < 80) return 13'($urandom_range(16, 1));
        if (pick < 90) return 13'd0;
        return 13'($urandom_range(8191, PAGE_BYTES + 1));
    endfunction

    function automatic int rand_entries();
        if ($urandom_range(99) < 80) return $urandom_range(8, 1);
        return $urandom_range(MAX_ENTRIES + 2, 9);
    endfunction

    task automatic test_empty_copy();
        send_item(OP_COPY, '0, '0, '0, 31'd100);
    endtask

    task automatic test_list_building();
        send_item(OP_CLEAR, '0, '0, '0, '0);
        send_item(OP_APPEND_SRC, 48'hFFFF_FFFF_FFF0, 13'd100, '0, '0);
        send_item(OP_APPEND_SRC, rand_addr(), 13'd0, '0, '0);
        send_item(OP_APPEND_SRC, '0, 13'h1FFF, '0, '0);
        send_item(OP_APPEND_SRC, rand_addr(), 13'(PAGE_BYTES), CNT_MAX, CNT_MAX);
        for (int i = 0; i < MAX_ENTRIES - 3; i++)
            send_item(OP_APPEND_SRC, rand_addr(), 13'($urandom_range(64, 1)), '0, '0);
        send_item(OP_APPEND_DST, 48'hFFFF_FFFF_FFFF, 13'(PAGE_BYTES), '0, '0);
        send_item(OP_APPEND_DST, rand_addr(), 13'd1, '0, '0);
    endtask

    task automatic test_copy_cases();
        send_item(OP_COPY, '0, '0, 31'd50, CNT_MAX);
        send_item(OP_COPY, '0, '0, '0, '0);
        send_item(OP_COPY, '0, '0, CNT_MAX, 31'd10);
        send_item(OP_COPY, '0, '0, '0, 31'd30);
        send_item(OP_CLEAR, '0, '0, '0, '0);
    endtask

    task automatic random_noise();
        send_item(t_opcode'($urandom_range(3)), rand_addr(), 13'($urandom),
                  rand_cnt(), rand_cnt());
    endtask

    task automatic test_random_plans(int item_goal);
        int          start;
        int          n_src;
        int          n_dst;
        int          src_bytes;
        int          dst_bytes;
        logic [30:0] offset;
        logic [30:0] req;
        int          pick;
        start = commands_sent;
        while (commands_sent - start < item_goal) begin
            gapless = (commands_sent - start > item_goal / 3) &&
                      (commands_sent - start < 2 * item_goal / 3);
            if ($urandom_range(99) < 85)
                send_item(OP_CLEAR, rand_addr(), 13'($urandom), rand_cnt(), rand_cnt());
            n_src = rand_entries();
            n_dst = rand_entries();
            for (int i = 0; i < n_src || i < n_dst; i++) begin
                if (i < n_src)
                    send_item(OP_APPEND_SRC, rand_addr(), rand_len(), rand_cnt(), rand_cnt());
                if (i < n_dst)
                    send_item(OP_APPEND_DST, rand_addr(), rand_len(), rand_cnt(), rand_cnt());
                if ($urandom_range(99) < 5) random_noise();
            end
            for (int c = $urandom_range(4, 2); c > 0; c--) begin
                src_bytes = 0;
                dst_bytes = 0;
                for (int i = 0; i < src_count; i++) src_bytes += src_len[i];
                for (int i = 0; i < dst_count; i++) dst_bytes += dst_len[i];
                pick = $urandom_range(99);
                if (pick < 60) offset = 31'($urandom_range(src_bytes + 16, 0));
                else if (pick < 80) offset = '0;
                else offset = rand_cnt();
                pick = $urandom_range(99);
                if (pick < 50) req = 31'($urandom_range(dst_bytes + 16, 0));
                else if (pick < 70) req = CNT_MAX;
                else if (pick < 80) req = '0;
                else req = rand_cnt();
                send_item(OP_COPY, rand_addr(), 13'($urandom), offset, req);
            end
            if ($urandom_range(99) < 10) random_noise();
        end
        gapless = 1'b0;
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = OP_CLEAR;
        src_count       = 0;
        dst_count       = 0;
        overflow_seen   = 1'b0;
        errors          = 0;
        commands_sent   = 0;
        copies_sent     = 0;
        segments_seen   = 0;
        summaries_seen  = 0;
        full_beats_seen = 0;
        gapless         = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_copy();
        test_list_building();
        test_copy_cases();
        test_random_plans(420);

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (planned_beats.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (planned_beats.size() != 0) begin
            $error("%0d expected beats never arrived", planned_beats.size());
            errors++;
        end

        $display("Sent %0d commands including %0d copies.", commands_sent, copies_sent);
        $display("Checked %0d segments, %0d copy summaries and %0d beats with list_full set.",
                 segments_seen, summaries_seen, full_beats_seen);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Run timed out.");
        $display("== FAIL ==");
        $finish;
    end

endmodule
